// ===== src/hwd_pkg.sv =====
// hwd_pkg: types, widths and constants shared by the heartbeat watchdog files.
// No dependencies.

package hwd_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int SLOTNUM_W  = 8;
   localparam int TICK_W     = 32;
   localparam int TIME_W     = 63;
   localparam int INTERVAL_W = 52;
   localparam int TP_W       = 10;
   localparam int MULT_W     = 4;
   localparam int MUL_B_W    = 10;
   localparam int PROD_W     = INTERVAL_W + MUL_B_W;
   localparam int LIMIT_W    = INTERVAL_W + MULT_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TP_W;

   localparam logic [MUL_B_W-1:0]   US_PER_MS      = MUL_B_W'(1000);
   localparam logic [TP_W-1:0]      TP_RESET       = TP_W'(10);
   localparam logic [MULT_W-1:0]    MULT_RESET     = MULT_W'(3);
   localparam logic [SLOT_W-1:0]    LAST_IDX       = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [SLOTNUM_W-1:0] SLOT_LIMIT     = SLOTNUM_W'(SLOT_COUNT);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MULT = 1'b1;

   // action codes
   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]     seen_time;
      logic [TICK_W-1:0]     sender_tick;
      logic [INTERVAL_W-1:0] interval;
   } slot_row_type;

   typedef struct packed {
      logic         wr_en;
      logic [SLOT_W-1:0] wr_addr;
      slot_row_type wr_row;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                  en;
      logic [INTERVAL_W-1:0] a;
      logic [MUL_B_W-1:0]    b;
   } mul_req_type;

endpackage

// ===== src/hwd_req_if.sv =====
// hwd_req_if: request channel of the heartbeat watchdog, valid/ready with payload.
// Depends on hwd_pkg.

interface hwd_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [hwd_pkg::SLOTNUM_W-1:0]  slot;
   logic [hwd_pkg::TICK_W-1:0]     sender_tick;
   logic [hwd_pkg::TIME_W-1:0]     now_us;

   modport source (output valid, action, slot, sender_tick, now_us, input ready);
   modport sink   (input valid, action, slot, sender_tick, now_us, output ready);
endinterface

// ===== src/hwd_rsp_if.sv =====
// hwd_rsp_if: response channel of the heartbeat watchdog, valid/ready with payload.
// Depends on hwd_pkg.

interface hwd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hwd_pkg::SLOTNUM_W-1:0]  slot_out;
   logic                           prev_offline;
   logic                           went_offline;
   logic                           slot_ignored;
   logic                           last;

   modport source (output valid, slot_out, prev_offline, went_offline, slot_ignored, last,
                   input ready);
   modport sink   (input valid, slot_out, prev_offline, went_offline, slot_ignored, last,
                   output ready);
endinterface

// ===== src/hwd_mul_unit.sv =====
// hwd_mul_unit: shared 52x10 multiplier with a registered product.
// Depends on hwd_pkg.

module hwd_mul_unit (
   input  logic                        clock,
   input  hwd_pkg::mul_req_type        mul_req,
   output logic [hwd_pkg::PROD_W-1:0]  product
);

   logic [hwd_pkg::PROD_W-1:0] product_ff;
   logic [hwd_pkg::PROD_W-1:0] product_in;

   always_comb begin
      product_in = product_ff;
      if (mul_req.en) begin
         product_in = hwd_pkg::PROD_W'(mul_req.a) * hwd_pkg::PROD_W'(mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== src/hwd_slot_mem.sv =====
// hwd_slot_mem: per-slot table of last time, last tick and learned interval.
// One write port, one registered read port. Depends on hwd_pkg.

module hwd_slot_mem (
   input  logic                  clock,
   input  hwd_pkg::mem_req_type  mem_req,
   output hwd_pkg::slot_row_type rd_row
);

   hwd_pkg::slot_row_type mem [hwd_pkg::SLOT_COUNT];
   hwd_pkg::slot_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_row;
      end
      rd_row_ff <= mem[mem_req.rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule

// ===== src/adaptive_heartbeat_watchdog_core.sv =====
// adaptive_heartbeat_watchdog_core: heartbeat watchdog over a table of sensor slots.
// Depends on hwd_pkg, hwd_req_if, hwd_rsp_if, hwd_mul_unit, hwd_slot_mem.
//
// Use: a beat on req_ch is either a packet (action 0) for one slot or a check
// (action 1) of all slots. A packet stores the time and sender tick, learns the
// interval from the tick difference, clears the offline mark and answers with
// one beat on rsp_ch. A check answers with one beat per slot, last on the final
// one, and marks offline every seen slot with a nonzero interval whose silence
// exceeds the multiplier times its interval. csr_we/csr_index/csr_wdata set the
// tick period and multiplier. Sequencing: req_ch.ready is high only between
// items. A packet makes two passes through the shared multiplier, then commits
// the table write and its result; an out-of-range slot goes straight to
// emitting its result; a check reads each slot, multiplies its interval by the
// multiplier, then emits its result, slot by slot. The single multiplier and
// the one table read port set this sequence. One result register sits on
// rsp_ch, so a new item is taken while the last result still waits.
// Reset: synchronous; clears seen and offline bits and loads tick period 10 and
// multiplier 3. No clearing pass is needed.
// Stall: a stalled rsp_ch holds the result and the sequencer waits on it.

module adaptive_heartbeat_watchdog_core (
   input  logic                          clock,
   input  logic                          reset,
   hwd_req_if.sink                       req_ch,
   hwd_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [hwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hwd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PKT_MUL1 = 3'd1;
   localparam logic [2:0] S_PKT_MUL2 = 3'd2;
   localparam logic [2:0] S_PKT_WRITE = 3'd3;
   localparam logic [2:0] S_CHK_MUL  = 3'd4;
   localparam logic [2:0] S_CHK_EMIT = 3'd5;
   localparam logic [2:0] S_IGN_EMIT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [hwd_pkg::SLOT_W-1:0]     idx_ff, idx_in;
   logic [hwd_pkg::SLOTNUM_W-1:0]  slot_ff, slot_in;
   logic [hwd_pkg::TICK_W-1:0]     tick_ff, tick_in;
   logic [hwd_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [hwd_pkg::TIME_W-1:0]     diff_ff, diff_in;
   logic                           gt_ff, gt_in;
   logic [hwd_pkg::SLOT_COUNT-1:0] seen_ff, seen_in;
   logic [hwd_pkg::SLOT_COUNT-1:0] offline_ff, offline_in;
   logic [hwd_pkg::TP_W-1:0]       tp_ff, tp_in;
   logic [hwd_pkg::MULT_W-1:0]     mult_ff, mult_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hwd_pkg::SLOTNUM_W-1:0]  out_slot_ff, out_slot_in;
   logic                           out_was_ff, out_was_in;
   logic                           out_went_ff, out_went_in;
   logic                           out_ign_ff, out_ign_in;
   logic                           out_last_ff, out_last_in;

   hwd_pkg::mem_req_type           mem_req;
   hwd_pkg::slot_row_type          rd_row;
   hwd_pkg::mul_req_type           mul_req;
   logic [hwd_pkg::PROD_W-1:0]     mul_prod;

   logic                           out_free;
   logic                           went;
   logic [hwd_pkg::TICK_W-1:0]     delta;
   logic [hwd_pkg::INTERVAL_W-1:0] new_interval;

   hwd_slot_mem u_slot_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_row  (rd_row)
   );

   hwd_mul_unit u_mul_unit (
      .clock   (clock),
      .mul_req (mul_req),
      .product (mul_prod)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign delta    = tick_ff - rd_row.sender_tick;
   // first packet of a slot leaves the interval at zero
   assign new_interval = seen_ff[idx_ff] ? mul_prod[hwd_pkg::INTERVAL_W-1:0] : '0;
   assign went = !offline_ff[idx_ff] && seen_ff[idx_ff] && (rd_row.interval != '0)
                 && gt_ff && (diff_ff > hwd_pkg::TIME_W'(mul_prod[hwd_pkg::LIMIT_W-1:0]));

   always_comb begin
      tp_in   = tp_ff;
      mult_in = mult_ff;
      if (csr_we) begin
         unique case (csr_index)
            hwd_pkg::CSR_TICK_PERIOD: tp_in = csr_wdata;
            hwd_pkg::CSR_TIMEOUT_MULT: mult_in = csr_wdata[hwd_pkg::MULT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      tick_in      = tick_ff;
      now_in       = now_ff;
      diff_in      = diff_ff;
      gt_in        = gt_ff;
      seen_in      = seen_ff;
      offline_in   = offline_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_slot_in  = out_slot_ff;
      out_was_in   = out_was_ff;
      out_went_in  = out_went_ff;
      out_ign_in   = out_ign_ff;
      out_last_in  = out_last_ff;

      mem_req.wr_en             = 1'b0;
      mem_req.wr_addr           = idx_ff;
      mem_req.wr_row.seen_time  = now_ff;
      mem_req.wr_row.sender_tick = tick_ff;
      mem_req.wr_row.interval   = new_interval;
      mem_req.rd_addr           = idx_ff;

      mul_req.en = 1'b0;
      mul_req.a  = hwd_pkg::INTERVAL_W'(delta);
      mul_req.b  = tp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               slot_in = req_ch.slot;
               tick_in = req_ch.sender_tick;
               now_in  = req_ch.now_us;
               if (req_ch.action == hwd_pkg::ACT_CHECK) begin
                  idx_in          = '0;
                  mem_req.rd_addr = '0;
                  state_in        = S_CHK_MUL;
               end else if (req_ch.slot >= hwd_pkg::SLOT_LIMIT) begin
                  state_in = S_IGN_EMIT;
               end else begin
                  idx_in          = req_ch.slot[hwd_pkg::SLOT_W-1:0];
                  mem_req.rd_addr = req_ch.slot[hwd_pkg::SLOT_W-1:0];
                  state_in        = S_PKT_MUL1;
               end
            end
         end
         S_PKT_MUL1: begin
            // tick difference times period in ms
            mul_req.en = 1'b1;
            state_in   = S_PKT_MUL2;
         end
         S_PKT_MUL2: begin
            // then times 1000 for microseconds
            mul_req.en = 1'b1;
            mul_req.a  = mul_prod[hwd_pkg::INTERVAL_W-1:0];
            mul_req.b  = hwd_pkg::US_PER_MS;
            state_in   = S_PKT_WRITE;
         end
         S_PKT_WRITE: begin
            if (out_free) begin
               mem_req.wr_en       = 1'b1;
               seen_in[idx_ff]     = 1'b1;
               offline_in[idx_ff]  = 1'b0;
               rsp_valid_in        = 1'b1;
               out_slot_in         = slot_ff;
               out_was_in          = offline_ff[idx_ff];
               out_went_in         = 1'b0;
               out_ign_in          = 1'b0;
               out_last_in         = 1'b1;
               state_in            = S_IDLE;
            end
         end
         S_CHK_MUL: begin
            // limit = multiplier * interval, silence in parallel
            mul_req.en = 1'b1;
            mul_req.a  = rd_row.interval;
            mul_req.b  = hwd_pkg::MUL_B_W'(mult_ff);
            diff_in    = now_ff - rd_row.seen_time;
            gt_in      = now_ff > rd_row.seen_time;
            state_in   = S_CHK_EMIT;
         end
         S_CHK_EMIT: begin
            if (out_free) begin
               if (went) begin
                  offline_in[idx_ff] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               out_slot_in  = hwd_pkg::SLOTNUM_W'(idx_ff);
               out_was_in   = 1'b0;
               out_went_in  = went;
               out_ign_in   = 1'b0;
               out_last_in  = (idx_ff == hwd_pkg::LAST_IDX);
               if (idx_ff == hwd_pkg::LAST_IDX) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in          = idx_ff + 1'b1;
                  mem_req.rd_addr = idx_ff + 1'b1;
                  state_in        = S_CHK_MUL;
               end
            end
         end
         S_IGN_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_slot_in  = slot_ff;
               out_was_in   = 1'b0;
               out_went_in  = 1'b0;
               out_ign_in   = 1'b1;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         seen_ff      <= '0;
         offline_ff   <= '0;
         tp_ff        <= hwd_pkg::TP_RESET;
         mult_ff      <= hwd_pkg::MULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         seen_ff      <= seen_in;
         offline_ff   <= offline_in;
         tp_ff        <= tp_in;
         mult_ff      <= mult_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      tick_ff     <= tick_in;
      now_ff      <= now_in;
      diff_ff     <= diff_in;
      gt_ff       <= gt_in;
      out_slot_ff <= out_slot_in;
      out_was_ff  <= out_was_in;
      out_went_ff <= out_went_in;
      out_ign_ff  <= out_ign_in;
      out_last_ff <= out_last_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.slot_out     = out_slot_ff;
   assign rsp_ch.prev_offline = out_was_ff;
   assign rsp_ch.went_offline = out_went_ff;
   assign rsp_ch.slot_ignored = out_ign_ff;
   assign rsp_ch.last         = out_last_ff;

   // a committed packet leaves its slot seen and online
   a_pkt_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PKT_WRITE && out_free) |=>
         (seen_ff[$past(idx_ff)] && !offline_ff[$past(idx_ff)]))
      else $error("packet commit did not update slot flags");

   // a slot reported as going offline is marked offline afterwards
   a_went_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK_EMIT && out_free && went) |=> offline_ff[$past(idx_ff)])
      else $error("went offline without offline mark");

   // only a slot seen before can go offline
   a_went_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK_EMIT && went) |-> seen_ff[idx_ff])
      else $error("unseen slot went offline");

   // packet and check flags never appear in the same beat
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_went_ff && (out_was_ff || out_ign_ff)))
      else $error("packet and check flags mixed in one beat");

   // an ignored beat carries a slot beyond the table
   a_ign_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ign_ff) |-> (out_slot_ff >= hwd_pkg::SLOT_LIMIT))
      else $error("in-range slot reported as ignored");

endmodule
